// ===== hdl/isb_pkg.sv =====
package isb_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int WIDTH_DEFAULT = 32;

   localparam int ACTION_W = 2;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_ERASE  = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE  = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_DN_RD,
      ST_DN_WR,
      ST_UP_RD,
      ST_UP_WR,
      ST_PLACE,
      ST_FILL
   } state_type;

   typedef enum logic [1:0] {
      WA_CUR,
      WA_POS,
      WA_COUNT
   } waddr_sel_type;

   typedef enum logic [1:0] {
      WD_VALUE,
      WD_ZERO,
      WD_RDATA
   } wdata_sel_type;

   typedef enum logic [1:0] {
      RA_POS,
      RA_CUR_M1,
      RA_CUR_P1
   } raddr_sel_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_LOAD_COUNT,
      CUR_LOAD_POS,
      CUR_INC,
      CUR_DEC
   } cur_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_POS_P1
   } cnt_op_type;

   typedef struct packed {
      logic          latch;
      logic          mem_we;
      waddr_sel_type wa_sel;
      wdata_sel_type wd_sel;
      raddr_sel_type ra_sel;
      cur_op_type    cur_op;
      cnt_op_type    cnt_op;
      logic          respond;
      status_type    rsp_code;
      logic          rsp_rdata;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       full;
      logic       pos_lt_cnt;
      logic       pos_in_depth;
      logic       pos_p1_lt_cnt;
      logic       cur_eq_pos;
      logic       cur_m1_eq_pos;
      logic       dn_last;
   } sts_type;

endpackage

// ===== hdl/isb_ctrl.sv =====
module isb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  isb_pkg::sts_type sts,
   output isb_pkg::cmd_type cmd,
   output logic             busy
);
   import isb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (sts.action)
               ACT_READ: begin
                  if (sts.pos_lt_cnt) state_in = ST_READ_WAIT;
               end
               ACT_ERASE: begin
                  if (sts.pos_lt_cnt && sts.pos_p1_lt_cnt) state_in = ST_DN_RD;
               end
               ACT_INSERT: begin
                  if (sts.pos_lt_cnt) begin
                     if (!sts.full) state_in = ST_UP_RD;
                  end else if (sts.pos_in_depth) begin
                     state_in = ST_FILL;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_READ_WAIT: state_in = ST_IDLE;
         ST_DN_RD:     state_in = ST_DN_WR;
         ST_DN_WR: begin
            state_in = sts.dn_last ? ST_IDLE : ST_DN_RD;
         end
         ST_UP_RD:     state_in = ST_UP_WR;
         ST_UP_WR: begin
            state_in = sts.cur_m1_eq_pos ? ST_PLACE : ST_UP_RD;
         end
         ST_PLACE:     state_in = ST_IDLE;
         ST_FILL: begin
            if (sts.cur_eq_pos) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.wa_sel    = WA_CUR;
      cmd.wd_sel    = WD_VALUE;
      cmd.ra_sel    = RA_POS;
      cmd.cur_op    = CUR_HOLD;
      cmd.cnt_op    = CNT_HOLD;
      cmd.rsp_code  = STS_DONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch = start;
         end
         ST_EXEC: begin
            case (sts.action)
               ACT_APPEND: begin
                  cmd.respond = 1'b1;
                  if (sts.full) begin
                     cmd.rsp_code = STS_FULL;
                  end else begin
                     cmd.mem_we = 1'b1;
                     cmd.wa_sel = WA_COUNT;
                     cmd.wd_sel = WD_VALUE;
                     cmd.cnt_op = CNT_INC;
                  end
               end
               ACT_READ: begin
                  if (sts.pos_lt_cnt) begin
                     cmd.ra_sel = RA_POS;
                  end else begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = STS_RANGE;
                  end
               end
               ACT_ERASE: begin
                  if (!sts.pos_lt_cnt) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = STS_RANGE;
                  end else if (sts.pos_p1_lt_cnt) begin
                     cmd.cur_op = CUR_LOAD_POS;
                  end else begin
                     cmd.cnt_op  = CNT_DEC;
                     cmd.respond = 1'b1;
                  end
               end
               ACT_INSERT: begin
                  if (sts.pos_lt_cnt ? sts.full : !sts.pos_in_depth) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = STS_FULL;
                  end else begin
                     cmd.cur_op = CUR_LOAD_COUNT;
                  end
               end
               default: cmd.respond = 1'b0;
            endcase
         end
         ST_READ_WAIT: begin
            cmd.respond   = 1'b1;
            cmd.rsp_rdata = 1'b1;
         end
         ST_DN_RD: begin
            cmd.ra_sel = RA_CUR_P1;
         end
         ST_DN_WR: begin
            cmd.mem_we = 1'b1;
            cmd.wa_sel = WA_CUR;
            cmd.wd_sel = WD_RDATA;
            cmd.cur_op = CUR_INC;
            if (sts.dn_last) begin
               cmd.cnt_op  = CNT_DEC;
               cmd.respond = 1'b1;
            end
         end
         ST_UP_RD: begin
            cmd.ra_sel = RA_CUR_M1;
         end
         ST_UP_WR: begin
            cmd.mem_we = 1'b1;
            cmd.wa_sel = WA_CUR;
            cmd.wd_sel = WD_RDATA;
            cmd.cur_op = CUR_DEC;
         end
         ST_PLACE: begin
            cmd.mem_we  = 1'b1;
            cmd.wa_sel  = WA_POS;
            cmd.wd_sel  = WD_VALUE;
            cmd.cnt_op  = CNT_INC;
            cmd.respond = 1'b1;
         end
         ST_FILL: begin
            cmd.mem_we = 1'b1;
            if (sts.cur_eq_pos) begin
               cmd.wa_sel  = WA_POS;
               cmd.wd_sel  = WD_VALUE;
               cmd.cnt_op  = CNT_POS_P1;
               cmd.respond = 1'b1;
            end else begin
               cmd.wa_sel = WA_CUR;
               cmd.wd_sel = WD_ZERO;
               cmd.cur_op = CUR_INC;
            end
         end
         default: cmd.respond = 1'b0;
      endcase
   end

endmodule

// ===== hdl/isb_datapath.sv =====
module isb_datapath #(
   parameter int DEPTH = isb_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = isb_pkg::WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic        [isb_pkg::ACTION_W-1:0] req_action,
   input  logic        [isb_pkg::POS_W-1:0]    req_position,
   input  logic signed [isb_pkg::VALUE_W-1:0]  req_element_value,
   input  isb_pkg::cmd_type                    cmd,
   output isb_pkg::sts_type                    sts,
   output logic                                rsp_strobe,
   output logic signed [isb_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic        [isb_pkg::COUNT_W-1:0]  rsp_element_count,
   output logic        [isb_pkg::STATUS_W-1:0] rsp_status
);
   import isb_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = CW + POS_W + 1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];

   action_type       action_ff;
   logic [POS_W-1:0] pos_ff;
   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] rdata_ff;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [CW-1:0]    count_ff, count_in;

   logic                rsp_strobe_ff;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic signed [63:0] req_ext;
   logic signed [63:0] rd_ext;
   logic [AW-1:0]      wa, ra, pos_a;
   logic [WIDTH-1:0]   wd;
   logic [CMP_W-1:0]   pos_c, cnt_c, cur_c;

   assign req_ext = req_element_value;
   assign rd_ext  = $signed(rdata_ff);
   assign pos_a   = AW'(pos_ff);
   assign pos_c   = CMP_W'(pos_ff);
   assign cnt_c   = CMP_W'(count_ff);
   assign cur_c   = CMP_W'(cur_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff <= action_type'(req_action);
         pos_ff    <= req_position;
         value_ff  <= req_ext[WIDTH-1:0];
      end
      cur_ff <= cur_in;
   end

   always_comb begin
      case (cmd.wa_sel)
         WA_CUR:   wa = cur_ff;
         WA_POS:   wa = pos_a;
         WA_COUNT: wa = AW'(count_ff);
         default:  wa = cur_ff;
      endcase
      case (cmd.wd_sel)
         WD_VALUE: wd = value_ff;
         WD_ZERO:  wd = '0;
         WD_RDATA: wd = rdata_ff;
         default:  wd = value_ff;
      endcase
      case (cmd.ra_sel)
         RA_POS:    ra = pos_a;
         RA_CUR_M1: ra = cur_ff - AW'(1);
         RA_CUR_P1: ra = cur_ff + AW'(1);
         default:   ra = pos_a;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) mem[wa] <= wd;
      rdata_ff <= mem[ra];
   end

   always_comb begin
      case (cmd.cur_op)
         CUR_HOLD:       cur_in = cur_ff;
         CUR_LOAD_COUNT: cur_in = AW'(count_ff);
         CUR_LOAD_POS:   cur_in = pos_a;
         CUR_INC:        cur_in = cur_ff + AW'(1);
         CUR_DEC:        cur_in = cur_ff - AW'(1);
         default:        cur_in = cur_ff;
      endcase
      case (cmd.cnt_op)
         CNT_HOLD:   count_in = count_ff;
         CNT_INC:    count_in = count_ff + CW'(1);
         CNT_DEC:    count_in = count_ff - CW'(1);
         CNT_POS_P1: count_in = CW'(pos_c + CMP_W'(1));
         default:    count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      sts.action        = action_ff;
      sts.full          = (cnt_c >= DEPTH_C);
      sts.pos_lt_cnt    = (pos_c < cnt_c);
      sts.pos_in_depth  = (pos_c < DEPTH_C);
      sts.pos_p1_lt_cnt = ((pos_c + CMP_W'(1)) < cnt_c);
      sts.cur_eq_pos    = (cur_c == pos_c);
      sts.cur_m1_eq_pos = (cur_c == (pos_c + CMP_W'(1)));
      sts.dn_last       = ((cur_c + CMP_W'(2)) >= cnt_c);
   end

   assign rsp_value_in = cmd.rsp_rdata ? rd_ext[VALUE_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= COUNT_W'(count_in);
         rsp_status_ff <= cmd.rsp_code;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ===== hdl/indexed_sequence_buffer.sv =====
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+----------------------------
// request   | req_action, req_position, req_element_value    | start high, busy low
// response  | rsp_read_value, rsp_element_count, rsp_status  | rsp_strobe, one cycle
//
// An item is accepted when start is high and busy low; its result is on the ports in the
// first cycle with busy low again. Append, read, a failed request and erasing the last
// element move no data; insert before the end moves elements p..n-1 up, insert past the end
// zero-fills n..p-1, erase moves p+1..n-1 down. Each move is a memory read, then a write.
// Synchronous reset empties the sequence; memory contents are left as they are.
// The receiver cannot stall: rsp_strobe marks each result for exactly one cycle.
module indexed_sequence_buffer #(
   parameter int DEPTH = isb_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = isb_pkg::WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [isb_pkg::ACTION_W-1:0] req_action,
   input  logic        [isb_pkg::POS_W-1:0]    req_position,
   input  logic signed [isb_pkg::VALUE_W-1:0]  req_element_value,
   output logic                                rsp_strobe,
   output logic signed [isb_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic        [isb_pkg::COUNT_W-1:0]  rsp_element_count,
   output logic        [isb_pkg::STATUS_W-1:0] rsp_status
);
   import isb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   isb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   isb_datapath #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_position      (req_position),
      .req_element_value (req_element_value),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count),
      .rsp_status        (rsp_status)
   );

   // an accepted item always raises busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // results come from a busy cycle, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held two cycles");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without work");

   // a failed request never reports a read value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STS_DONE)) |-> (rsp_read_value == '0))
      else $error("failed request returned data");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import isb_pkg::*;

   localparam int SEQ_DEPTH    = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1700;
   localparam int QUIET_TAIL   = 200;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 140;

   typedef struct {
      logic signed [VALUE_W-1:0] read_value;
      logic        [COUNT_W-1:0] count;
      status_type                status;
   } seq_reply_type;

   typedef struct {
      action_type                act;
      logic        [POS_W-1:0]   pos;
      logic signed [VALUE_W-1:0] value;
      bit                        fixed;
      logic signed [VALUE_W-1:0] read_value;
      logic        [COUNT_W-1:0] count;
      status_type                status;
   } table_row_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic        [ACTION_W-1:0]  req_action;
   logic        [POS_W-1:0]     req_position;
   logic signed [VALUE_W-1:0]   req_element_value;
   logic                        rsp_strobe;
   logic signed [VALUE_W-1:0]   rsp_read_value;
   logic        [COUNT_W-1:0]   rsp_element_count;
   logic        [STATUS_W-1:0]  rsp_status;

   // shadow copy of the sequence
   logic signed [VALUE_W-1:0]   shadow_elems [0:SEQ_DEPTH-1];
   int                          shadow_count;
   bit                          growing;

   seq_reply_type               replies_due [$];
   table_row_type               directed_rows [$];
   seq_reply_type               due;
   int                          error_count;
   int                          quiet_cycles;

   indexed_sequence_buffer dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_position      (req_position),
      .req_element_value (req_element_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count),
      .rsp_status        (rsp_status)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic seq_reply_type shadow_sequence_op(input action_type act, input int pos,
                                                        input logic signed [VALUE_W-1:0] value);
      seq_reply_type r;
      int            i;
      r.read_value = '0;
      r.status     = STS_DONE;
      case (act)
         ACT_APPEND: begin
            if (shadow_count >= SEQ_DEPTH) begin
               r.status = STS_FULL;
            end else begin
               shadow_elems[shadow_count] = value;
               shadow_count++;
            end
         end
         ACT_INSERT: begin
            if (pos < shadow_count) begin
               if (shadow_count >= SEQ_DEPTH) begin
                  r.status = STS_FULL;
               end else begin
                  for (i = shadow_count; i > pos; i--) shadow_elems[i] = shadow_elems[i-1];
                  shadow_elems[pos] = value;
                  shadow_count++;
               end
            end else if (pos + 1 > SEQ_DEPTH) begin
               r.status = STS_FULL;
            end else begin
               // past the end: zero the gap
               for (i = shadow_count; i < pos; i++) shadow_elems[i] = '0;
               shadow_elems[pos] = value;
               shadow_count = pos + 1;
            end
         end
         ACT_ERASE: begin
            if (pos >= shadow_count) begin
               r.status = STS_RANGE;
            end else begin
               for (i = pos; i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i+1];
               shadow_count--;
            end
         end
         default: begin
            if (pos >= shadow_count) r.status = STS_RANGE;
            else r.read_value = shadow_elems[pos];
         end
      endcase
      r.count = shadow_count[COUNT_W-1:0];
      return r;
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic table_row(input action_type act, input logic [POS_W-1:0] pos,
                            input logic signed [VALUE_W-1:0] value, input bit fixed,
                            input logic signed [VALUE_W-1:0] read_value,
                            input logic [COUNT_W-1:0] count, input status_type status);
      table_row_type row;
      row.act        = act;
      row.pos        = pos;
      row.value      = value;
      row.fixed      = fixed;
      row.read_value = read_value;
      row.count      = count;
      row.status     = status;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // holds the item until the block takes it, then advances the shadow
   task automatic issue_request(input action_type act, input logic [POS_W-1:0] pos,
                                input logic signed [VALUE_W-1:0] value,
                                output seq_reply_type predicted);
      req_action        <= act;
      req_position      <= pos;
      req_element_value <= value;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = shadow_sequence_op(act, pos, value);
   endtask

   task automatic idle_sender(input int cycles);
      start             <= 1'b0;
      req_action        <= ACTION_W'($urandom);
      req_position      <= POS_W'($urandom);
      req_element_value <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic pick_request(output action_type act, output logic [POS_W-1:0] pos,
                               output logic signed [VALUE_W-1:0] value);
      int r;
      int p;
      if (shadow_count >= SEQ_DEPTH) growing = 1'b0;
      else if (shadow_count == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) < 1) growing = !growing;

      r = $urandom_range(0, 99);
      if (growing) begin
         if (r < 35) act = ACT_APPEND;
         else if (r < 65) act = ACT_INSERT;
         else if (r < 80) act = ACT_ERASE;
         else act = ACT_READ;
      end else begin
         if (r < 10) act = ACT_APPEND;
         else if (r < 20) act = ACT_INSERT;
         else if (r < 70) act = ACT_ERASE;
         else act = ACT_READ;
      end

      r = $urandom_range(0, 99);
      if (r < 8 || shadow_count == 0) begin
         p = $urandom_range(0, 63);
      end else if (act == ACT_INSERT && r < 20) begin
         // at or just past the end
         p = shadow_count + $urandom_range(0, 3);
         if (p > 63) p = 63;
      end else begin
         p = $urandom_range(0, shadow_count - 1);
      end
      pos = POS_W'(p);

      case ($urandom_range(0, 9))
         0:       value = 32'sh8000_0000;
         1:       value = 32'sh7FFF_FFFF;
         2:       value = -32'sd1;
         3:       value = 32'sd0;
         default: value = $urandom;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (replies_due.size() == 0) begin
            flag_error("result with no request outstanding");
         end else begin
            due = replies_due.pop_front();
            if (rsp_read_value !== due.read_value)
               flag_error($sformatf("read_value %0d, want %0d", rsp_read_value, due.read_value));
            if (rsp_element_count !== due.count)
               flag_error($sformatf("element_count %0d, want %0d", rsp_element_count, due.count));
            if (rsp_status !== due.status)
               flag_error($sformatf("status %0d, want %0d", rsp_status, due.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((!reset && start && busy === 1'b0) || rsp_strobe === 1'b1) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      action_type                act;
      logic        [POS_W-1:0]   pos;
      logic signed [VALUE_W-1:0] value;
      seq_reply_type             predicted;
      seq_reply_type             typed;
      table_row_type             row;
      int                        gap_pct;
      int                        n;

      reset             = 1'b1;
      start             = 1'b0;
      req_action        = '0;
      req_position      = '0;
      req_element_value = '0;
      shadow_count      = 0;
      growing           = 1'b1;
      for (n = 0; n < SEQ_DEPTH; n++) shadow_elems[n] = '0;

      // empty, then one element: reads and erases at the end are out of range
      table_row(ACT_READ,   6'd0,  32'sd0,          1, 32'sd0, 7'd0,  STS_RANGE);
      table_row(ACT_ERASE,  6'd0,  32'sd0,          1, 32'sd0, 7'd0,  STS_RANGE);
      table_row(ACT_APPEND, 6'd0,  32'sh7FFF_FFFF,  1, 32'sd0, 7'd1,  STS_DONE);
      table_row(ACT_READ,   6'd1,  32'sd0,          1, 32'sd0, 7'd1,  STS_RANGE);
      table_row(ACT_ERASE,  6'd1,  32'sd0,          1, 32'sd0, 7'd1,  STS_RANGE);
      table_row(ACT_READ,   6'd0,  32'sd0,          1, 32'sh7FFF_FFFF, 7'd1, STS_DONE);
      table_row(ACT_APPEND, 6'd63, 32'sh8000_0000,  1, 32'sd0, 7'd2,  STS_DONE);
      // insert before the last element, then at the head
      table_row(ACT_INSERT, 6'd1,  -32'sd1,         0, 32'sd0, 7'd0,  STS_DONE);
      table_row(ACT_INSERT, 6'd0,  32'sh1234_5678,  0, 32'sd0, 7'd0,  STS_DONE);
      table_row(ACT_READ,   6'd2,  32'sd0,          0, 32'sd0, 7'd0,  STS_DONE);
      // insert past the end zero-fills the gap
      table_row(ACT_INSERT, 6'd7,  32'shAAAA_AAAA,  0, 32'sd0, 7'd0,  STS_DONE);
      table_row(ACT_READ,   6'd5,  32'sd0,          1, 32'sd0, 7'd8,  STS_DONE);
      table_row(ACT_ERASE,  6'd7,  32'sd0,          0, 32'sd0, 7'd0,  STS_DONE);
      table_row(ACT_ERASE,  6'd0,  32'sd0,          0, 32'sd0, 7'd0,  STS_DONE);
      // fill to the top in one step, then every full case
      table_row(ACT_INSERT, 6'd63, 32'sh5555_5555,  1, 32'sd0, 7'd64, STS_DONE);
      table_row(ACT_APPEND, 6'd0,  32'sd1,          1, 32'sd0, 7'd64, STS_FULL);
      table_row(ACT_INSERT, 6'd10, 32'sd2,          1, 32'sd0, 7'd64, STS_FULL);
      table_row(ACT_INSERT, 6'd63, 32'sd3,          1, 32'sd0, 7'd64, STS_FULL);
      table_row(ACT_READ,   6'd63, 32'sd0,          1, 32'sh5555_5555, 7'd64, STS_DONE);
      table_row(ACT_ERASE,  6'd63, 32'sd0,          1, 32'sd0, 7'd63, STS_DONE);
      table_row(ACT_ERASE,  6'd0,  32'sd0,          0, 32'sd0, 7'd0,  STS_DONE);
      table_row(ACT_READ,   6'd63, 32'sd0,          1, 32'sd0, 7'd62, STS_RANGE);
      table_row(ACT_INSERT, 6'd62, 32'sd3,          0, 32'sd0, 7'd0,  STS_DONE);
      table_row(ACT_READ,   6'd0,  32'sd0,          0, 32'sd0, 7'd0,  STS_DONE);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < directed_rows.size(); n++) begin
         row = directed_rows[n];
         issue_request(row.act, row.pos, row.value, predicted);
         if (row.fixed) begin
            typed.read_value = row.read_value;
            typed.count      = row.count;
            typed.status     = row.status;
            replies_due.insert(replies_due.size(), typed);
         end else begin
            replies_due.insert(replies_due.size(), predicted);
         end
         if ($urandom_range(0, 99) < 30) idle_sender($urandom_range(1, 18));
      end

      gap_pct = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 10;
               default: gap_pct = 35;
            endcase
         end
         // let the block drain completely once mid-run
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (replies_due.size() != 0);
         end
         pick_request(act, pos, value);
         issue_request(act, pos, value, predicted);
         replies_due.insert(replies_due.size(), predicted);
         if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < gap_pct)
            idle_sender($urandom_range(1, 18));
      end

      start <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
